FILE: hw/rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/wrms_pkg.sv
package wrms_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int SUM_W       = 20;
    localparam int LEN_W       = 5;
    localparam int FS_W        = 14;
    localparam int RMS_W       = 14;
    localparam int MAX_WINDOW  = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = FS_W;

    localparam int LEN_RESET   = 10;
    localparam int FS_RESET    = 300;

    localparam int FULL_CODE_SQ = 65025;
    localparam int RMS_MAX      = 9999;

    localparam int PROD1_W    = SUM_W + FS_W;
    localparam int NUM_W      = PROD1_W + FS_W;
    localparam int DIVISOR_W  = 20;
    localparam int ROOT_W     = NUM_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DIV_STEPS  = NUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = 6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW_LENGTH = CFG_ADDR_W'(0),
        CFG_FULL_SCALE    = CFG_ADDR_W'(1)
    } t_cfg_addr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_eng_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
    } t_window;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [RMS_W-1:0] rms;
    } t_eng_status;

endpackage

FILE: hw/rtl/wrms_if.sv
interface wrms_sample_if import wrms_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wrms_result_if import wrms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RMS_W-1:0] rms_centivolts;

    modport source (output valid, output rms_centivolts, input ready);
    modport sink   (input valid, input rms_centivolts, output ready);
endinterface

interface wrms_cfg_if import wrms_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: hw/rtl/wrms_accum.sv
module wrms_accum import wrms_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [LEN_W-1:0]    i_len_cfg,
    output t_window             o_window
);

    logic [SUM_W-1:0]      r_sum;
    logic [LEN_W-1:0]      r_count;
    logic [SUM_W-1:0]      n_sum;
    logic [LEN_W-1:0]      n_count;

    logic [2*SAMPLE_W-1:0] square;
    logic [SUM_W:0]        total;
    logic [SUM_W-1:0]      sat_sum;
    logic [LEN_W-1:0]      len_eff;
    logic [LEN_W-1:0]      count_inc;
    logic                  close;

    always_comb begin
        square    = (2*SAMPLE_W)'(i_sample) * (2*SAMPLE_W)'(i_sample);
        total     = {1'b0, r_sum} + (SUM_W+1)'(square);
        sat_sum   = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
        count_inc = r_count + LEN_W'(1);

        // zero means one, clamp at the window maximum
        if (i_len_cfg == '0) begin
            len_eff = LEN_W'(1);
        end else if (i_len_cfg > LEN_W'(MAX_WINDOW)) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = i_len_cfg;
        end

        close = (count_inc >= len_eff);

        n_sum   = r_sum;
        n_count = r_count;
        if (i_accept) begin
            if (close) begin
                n_sum   = '0;
                n_count = '0;
            end else begin
                n_sum   = sat_sum;
                n_count = count_inc;
            end
        end

        o_window.start = i_accept && close;
        o_window.sum   = sat_sum;
        o_window.len   = len_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/wrms_sub.sv
module wrms_sub import wrms_pkg::*; (
    input  logic [REM_W-1:0] i_a,
    input  logic [REM_W-1:0] i_b,
    output logic [REM_W-1:0] o_diff,
    output logic             o_ge
);

    logic [REM_W:0] full;

    assign full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = full[REM_W-1:0];
    assign o_ge   = !full[REM_W];

endmodule

FILE: hw/rtl/wrms_engine.sv
module wrms_engine import wrms_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_window         i_window,
    input  logic [FS_W-1:0] i_fs,
    input  logic            i_take,
    output t_eng_status     o_status
);

    t_eng_state            r_state;
    t_eng_state            n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [NUM_W-1:0]      r_acc;
    logic [NUM_W-1:0]      n_acc;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W-1:0]  n_div;
    logic [REM_W-1:0]      r_rem;
    logic [REM_W-1:0]      n_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [ROOT_W-1:0]     n_root;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      n_len;

    logic [PROD1_W-1:0]    prod1;
    logic [NUM_W-1:0]      prod2;
    logic [DIVISOR_W-1:0]  divisor;
    logic [REM_W-1:0]      sub_a;
    logic [REM_W-1:0]      sub_b;
    logic [REM_W-1:0]      sub_diff;
    logic                  sub_ge;

    wrms_sub u_sub (
        .i_a    (sub_a),
        .i_b    (sub_b),
        .o_diff (sub_diff),
        .o_ge   (sub_ge)
    );

    assign prod1   = PROD1_W'(r_acc[SUM_W-1:0]) * PROD1_W'(i_fs);
    assign prod2   = NUM_W'(r_acc[PROD1_W-1:0]) * NUM_W'(i_fs);
    assign divisor = DIVISOR_W'(r_len) * DIVISOR_W'(FULL_CODE_SQ);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_div   = r_div;
        n_rem   = r_rem;
        n_root  = r_root;
        n_len   = r_len;
        sub_a   = '0;
        sub_b   = '0;

        o_status.busy = (r_state != ST_IDLE);
        o_status.done = 1'b0;
        o_status.rms  = (r_root > ROOT_W'(RMS_MAX)) ? RMS_W'(RMS_MAX) : r_root[RMS_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_window.start) begin
                    n_acc   = NUM_W'(i_window.sum);
                    n_len   = i_window.len;
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                n_acc   = NUM_W'(prod1);
                n_div   = divisor;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_acc   = prod2;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle
                sub_a = REM_W'({r_rem[DIVISOR_W-1:0], r_acc[NUM_W-1]});
                sub_b = REM_W'(r_div);
                n_acc = {r_acc[NUM_W-2:0], sub_ge};
                n_rem = sub_ge ? sub_diff : sub_a;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // one root digit per cycle
                sub_a  = {r_rem[REM_W-3:0], r_acc[NUM_W-1 -: 2]};
                sub_b  = {r_root, 2'b01};
                n_acc  = {r_acc[NUM_W-3:0], 2'b00};
                n_rem  = sub_ge ? sub_diff : sub_a;
                n_root = {r_root[ROOT_W-2:0], sub_ge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_status.done = 1'b1;
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_len  <= n_len;
    end

endmodule

FILE: hw/rtl/windowed_rms_voltage_top.sv
// Windowed RMS meter: squares each unsigned 8-bit sample into a running sum and, once
// window_length samples (1..16) are in, returns floor(sqrt(sum*fs*fs/(len*65025))) in
// centivolts, capped at 9999, then starts a fresh window. A sample that does not close a
// window is accepted and the block is ready again at once. The sample that closes a window
// holds off the next request while the engine runs: multiply states ST_MUL1 and ST_MUL2,
// then restoring divide and square root, both stepping through one shared subtractor one
// bit or digit per cycle, and handoff state ST_DONE, which waits until the output register
// is free or being read. The result sits in an output register, so the next request is
// accepted while a result still waits. Configuration is written with the block idle; the
// block does not enforce this, so the user must. Unknown register indexes are ignored.
module windowed_rms_voltage_top import wrms_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wrms_sample_if.sink   i_sample,
    wrms_result_if.source o_result,
    wrms_cfg_if.sink      i_cfg
);

    logic [LEN_W-1:0] r_len_cfg;
    logic [FS_W-1:0]  r_fs_cfg;
    logic             r_out_valid;
    logic [RMS_W-1:0] r_out_rms;

    t_window          window;
    t_eng_status      status;
    logic             accept;
    logic             take;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !status.busy;
    assign accept         = i_sample.valid && i_sample.ready;
    assign take           = status.done && (!r_out_valid || o_result.ready);

    assign o_result.valid          = r_out_valid;
    assign o_result.rms_centivolts = r_out_rms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= LEN_W'(LEN_RESET);
            r_fs_cfg  <= FS_W'(FS_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.addr)
                CFG_WINDOW_LENGTH: r_len_cfg <= i_cfg.data[LEN_W-1:0];
                CFG_FULL_SCALE:    r_fs_cfg  <= i_cfg.data[FS_W-1:0];
                default:           ;
            endcase
        end
    end

    wrms_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_sample  (i_sample.sample),
        .i_len_cfg (r_len_cfg),
        .o_window  (window)
    );

    wrms_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_window (window),
        .i_fs     (r_fs_cfg),
        .i_take   (take),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_rms <= status.rms;
        end
    end

endmodule

FILE: hw/rtl/wrms_checker.sv
`include "assert_macros.svh"

module wrms_checker import wrms_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [RMS_W-1:0] i_out_rms
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_rms), "stalled result changed")
    `ASSERT_IMPLIES(a_rms_range, i_clk, i_rst_n, i_out_valid, i_out_rms <= RMS_W'(RMS_MAX), "result above full range")
    `ASSERT_IMPLIES(a_busy_before_result, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result appeared while input was ready")
    `ASSERT_IMPLIES(a_no_result_after_request, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_valid && i_in_ready), "result right after a request")

endmodule

bind windowed_rms_voltage_top wrms_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_rms   (o_result.rms_centivolts)
);
